>>> rtl/core/integer_to_ascii_formatter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Shorthand for clocked, reset-gated property checks. The macros expect
// clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ITAF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itaf check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ITAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itaf check failed");

`endif

>>> rtl/core/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Types, constants and character helpers shared by the formatter modules.
// ----------------------------------------------------------------------------
package itaf_pkg;

  // Depth of the command queue between front and back.
  localparam int unsigned FIFO_DEPTH = 2;

  // Input action codes.
  typedef enum logic [2:0] {
    ACT_SDEC = 3'd0,
    ACT_UDEC = 3'd1,
    ACT_HEXL = 3'd2,
    ACT_HEXU = 3'd3,
    ACT_PTR  = 3'd4
  } action_e;

  // Digit format that the back end carries out.
  typedef enum logic [1:0] {
    FMT_DEC   = 2'd0,
    FMT_HEX32 = 2'd1,
    FMT_HEX64 = 2'd2,
    FMT_NIL   = 2'd3
  } fmt_e;

  // Fixed text that goes out ahead of the digits.
  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_MINUS = 2'd1,
    PFX_0X    = 2'd2,
    PFX_NIL   = 2'd3
  } pfx_e;

  // One input beat.
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  char_out;
    logic        last;
    logic [31:0] char_count;
  } out_item_t;

  // Classified command handed from front to back.
  typedef struct packed {
    fmt_e        fmt;
    pfx_e        pfx;
    logic        upper;
    logic [63:0] value;
  } cmd_t;

  localparam logic [127:0] HEX_LOWER = "0123456789abcdef";
  localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";
  localparam logic [39:0]  NIL_TEXT  = "(nil)";
  localparam logic [15:0]  HEX_LEAD  = "0x";
  localparam logic [7:0]   CH_MINUS  = "-";

  // Character for one hex or decimal digit.
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [6:0] pos;
    pos = {4'd15 - nib, 3'b000};
    digit_char = upper ? HEX_UPPER[pos +: 8] : HEX_LOWER[pos +: 8];
  endfunction

  // Number of prefix characters.
  function automatic logic [2:0] prefix_len(input pfx_e pfx);
    case (pfx)
      PFX_MINUS: prefix_len = 3'd1;
      PFX_0X:    prefix_len = 3'd2;
      PFX_NIL:   prefix_len = 3'd5;
      default:   prefix_len = 3'd1;
    endcase
  endfunction

  // Prefix character at position idx, counted from the first one sent.
  function automatic logic [7:0] prefix_char(input pfx_e pfx, input logic [2:0] idx);
    logic [5:0] pos;
    pos = {3'd4 - idx, 3'b000};
    case (pfx)
      PFX_MINUS: prefix_char = CH_MINUS;
      PFX_0X:    prefix_char = idx[0] ? HEX_LEAD[7:0] : HEX_LEAD[15:8];
      PFX_NIL:   prefix_char = NIL_TEXT[pos +: 8];
      default:   prefix_char = CH_MINUS;
    endcase
  endfunction

endpackage

>>> rtl/core/itaf_fifo.sv
// ----------------------------------------------------------------------------
// itaf_fifo
// Small command queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module itaf_fifo import itaf_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_cmd_i,
  output logic full_o,
  input  logic rd_en_i,
  output cmd_t rd_cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

>>> rtl/core/itaf_front.sv
// ----------------------------------------------------------------------------
// itaf_front
// Accepts input beats and classifies them into format commands.
// ----------------------------------------------------------------------------
module itaf_front import itaf_pkg::*; (
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     q_wr_o,
  output cmd_t     q_cmd_o
);

  logic [31:0] low;
  logic        known;

  assign low  = in_item_i.value[31:0];
  assign full = q_full_i;

  // Map the action to a digit format and a prefix; negative values are
  // turned into their magnitude here, which also covers the most negative
  // value since its two's complement is itself read as unsigned.
  always_comb begin
    known           = 1'b1;
    q_cmd_o.fmt     = FMT_DEC;
    q_cmd_o.pfx     = PFX_NONE;
    q_cmd_o.upper   = 1'b0;
    q_cmd_o.value   = {32'd0, low};
    case (in_item_i.action)
      ACT_SDEC: begin
        if (low[31]) begin
          q_cmd_o.pfx   = PFX_MINUS;
          q_cmd_o.value = {32'd0, 32'd0 - low};
        end
      end
      ACT_UDEC: begin
        q_cmd_o.fmt = FMT_DEC;
      end
      ACT_HEXL: begin
        q_cmd_o.fmt = FMT_HEX32;
      end
      ACT_HEXU: begin
        q_cmd_o.fmt   = FMT_HEX32;
        q_cmd_o.upper = 1'b1;
      end
      ACT_PTR: begin
        q_cmd_o.value = in_item_i.value;
        if (in_item_i.value == 64'd0) begin
          q_cmd_o.fmt = FMT_NIL;
          q_cmd_o.pfx = PFX_NIL;
        end else begin
          q_cmd_o.fmt = FMT_HEX64;
          q_cmd_o.pfx = PFX_0X;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Undefined actions are taken and dropped without a command.
  assign q_wr_o = push && !q_full_i && known;

endmodule

>>> rtl/core/itaf_back.sv
// ----------------------------------------------------------------------------
// itaf_back
// Executes format commands: binary to BCD conversion, leading zero skip,
// and emission of prefix and digit characters through an output register.
// ----------------------------------------------------------------------------
module itaf_back import itaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CONV   = 3'd1;
  localparam logic [2:0] ST_SKIP   = 3'd2;
  localparam logic [2:0] ST_PREFIX = 3'd3;
  localparam logic [2:0] ST_DIGIT  = 3'd4;

  // Two binary bits per conversion step over a 32-bit magnitude.
  localparam logic [3:0] CONV_LAST = 4'd15;

  // One shift-and-add-3 step on {bcd, binary}.
  function automatic logic [71:0] dabble(input logic [71:0] x);
    logic [71:0] y;
    y = x;
    for (int i = 0; i < 10; i++) begin
      if (y[32 + 4*i +: 4] >= 4'd5) begin
        y[32 + 4*i +: 4] = y[32 + 4*i +: 4] + 4'd3;
      end
    end
    dabble = {y[70:0], 1'b0};
  endfunction

  logic [2:0]  state_q, state_d;
  pfx_e        pfx_q, pfx_d;
  logic        upper_q, upper_d;
  logic [71:0] conv_q, conv_d;
  logic [71:0] conv_step;
  logic [3:0]  step_q, step_d;
  logic [63:0] dig_q, dig_d;
  logic [4:0]  ndig_q, ndig_d;
  logic [2:0]  pidx_q, pidx_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [31:0] count_q, count_d;
  logic        out_free;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;

  assign out_free   = !out_valid_q || pop;
  assign conv_step  = dabble(dabble(conv_q));
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  // Sequencer for one command.
  always_comb begin
    state_d   = state_q;
    pfx_d     = pfx_q;
    upper_d   = upper_q;
    conv_d    = conv_q;
    step_d    = step_q;
    dig_d     = dig_q;
    ndig_d    = ndig_q;
    pidx_d    = pidx_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_char = digit_char(dig_q[63:60], upper_q);
    emit_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          pfx_d   = q_cmd_i.pfx;
          upper_d = q_cmd_i.upper;
          pidx_d  = '0;
          case (q_cmd_i.fmt)
            FMT_DEC: begin
              conv_d  = {40'd0, q_cmd_i.value[31:0]};
              step_d  = '0;
              state_d = ST_CONV;
            end
            FMT_HEX32: begin
              dig_d   = {q_cmd_i.value[31:0], 32'd0};
              ndig_d  = 5'd8;
              state_d = ST_SKIP;
            end
            FMT_HEX64: begin
              dig_d   = q_cmd_i.value;
              ndig_d  = 5'd16;
              state_d = ST_SKIP;
            end
            default: begin
              state_d = ST_PREFIX;
            end
          endcase
        end
      end
      ST_CONV: begin
        conv_d = conv_step;
        step_d = step_q + 1'b1;
        if (step_q == CONV_LAST) begin
          dig_d   = {conv_step[71:32], 24'd0};
          ndig_d  = 5'd10;
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop one leading zero digit a cycle, keeping at least one digit.
        if (dig_q[63:60] == 4'd0 && ndig_q > 5'd1) begin
          dig_d  = {dig_q[59:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = (pfx_q == PFX_NONE) ? ST_DIGIT : ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        emit_char = prefix_char(pfx_q, pidx_q);
        emit_last = (pfx_q == PFX_NIL) && (pidx_q == prefix_len(pfx_q) - 1'b1);
        if (out_free) begin
          emit   = 1'b1;
          pidx_d = pidx_q + 1'b1;
          if (pidx_q == prefix_len(pfx_q) - 1'b1) begin
            state_d = (pfx_q == PFX_NIL) ? ST_IDLE : ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        emit_last = (ndig_q == 5'd1);
        if (out_free) begin
          emit   = 1'b1;
          dig_d  = {dig_q[59:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
          if (ndig_q == 5'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register and running character count.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    count_d     = count_q;
    if (emit) begin
      count_d          = count_q + 32'd1;
      out_valid_d      = 1'b1;
      out_d.char_out   = emit_char;
      out_d.last       = emit_last;
      out_d.char_count = count_q + 32'd1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    pfx_q   <= pfx_d;
    upper_q <= upper_d;
    conv_q  <= conv_d;
    step_q  <= step_d;
    dig_q   <= dig_d;
    ndig_q  <= ndig_d;
    pidx_q  <= pidx_d;
    out_q   <= out_d;
  end

endmodule

>>> rtl/core/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one number per input beat as ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Each input beat carries an action and a value; the block sends the text
// as result beats, most significant character first, with last set on the
// final one and a running character count on every beat. Actions 5 to 7
// are taken and produce nothing. A command queue of FifoDepth entries sits
// between the classifying front and the back end, so input beats keep
// flowing while text goes out. The back end handles one item at a time:
// it takes the command, runs the binary to BCD conversion for the decimal
// modes (two bits a cycle), drops suppressed leading zeros one at a time,
// then sends the prefix and digit characters while the result side keeps
// popping.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top import itaf_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic q_full, q_wr, q_empty, q_pop;
  cmd_t q_wr_cmd, q_rd_cmd;

  // Front: accept and classify.
  itaf_front u_front (
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_cmd_o   (q_wr_cmd)
  );

  // Command queue.
  itaf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_wr),
    .wr_cmd_i (q_wr_cmd),
    .full_o   (q_full),
    .rd_en_i  (q_pop),
    .rd_cmd_o (q_rd_cmd),
    .empty_o  (q_empty)
  );

  // Back: convert and emit.
  itaf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_rd_cmd),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

>>> rtl/core/itaf_checker.sv
// ----------------------------------------------------------------------------
// itaf_checker
// Port-level checks on the result stream of the formatter.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_top_macros.svh"

module itaf_checker import itaf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  logic        seen_q;
  logic [31:0] prev_count_q;
  logic        out_beat;

  assign out_beat = pop && !empty;

  // Track the count of the previous result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      prev_count_q <= '0;
    end else if (out_beat) begin
      seen_q       <= 1'b1;
      prev_count_q <= out_item_o.char_count;
    end
  end

  // A waiting result beat holds until popped.
  `ITAF_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_item_o))

  // The first beat after reset counts one, each later beat one more.
  `ITAF_ASSERT_NOW(a_count_first, out_beat && !seen_q, out_item_o.char_count == 32'd1)
  `ITAF_ASSERT_NOW(a_count_step, out_beat && seen_q,
                   out_item_o.char_count == prev_count_q + 32'd1)

  // Only characters of the formatted alphabet appear.
  `ITAF_ASSERT_NOW(a_char_range, !empty,
                   out_item_o.char_out >= 8'h28 && out_item_o.char_out <= 8'h78)

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_checker (.*);
